FILE: rtl/att_pkg.sv
`default_nettype none

package att_pkg;

    localparam int VAL_W = 48;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_ADD   = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF_RD,
        S_MOD,
        S_UP,
        S_Q_RD,
        S_Q_LEAF,
        S_Q_UP,
        S_DONE
    } state_t;

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] sum;
        sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            sat_add = sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            sat_add = sum[VAL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/att_node_ram.sv
`default_nettype none

module att_node_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 58
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_a_addr,
    output logic      [DATA_W-1:0] rd_a_data,
    input  wire logic [ADDR_W-1:0] rd_b_addr,
    output logic      [DATA_W-1:0] rd_b_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/att_node_cmp.sv
`default_nettype none

module att_node_cmp #(
    parameter int IDX_W = 10
) (
    input  wire logic [att_pkg::VAL_W-1:0] a_val,
    input  wire logic [IDX_W-1:0]          a_idx,
    input  wire logic [att_pkg::VAL_W-1:0] b_val,
    input  wire logic [IDX_W-1:0]          b_idx,
    input  wire logic                      a_wins_ties,
    output logic      [att_pkg::VAL_W-1:0] win_val,
    output logic      [IDX_W-1:0]          win_idx
);

    import att_pkg::*;

    logic take_a;

    always_comb begin
        take_a = ($signed(a_val) > $signed(b_val)) || ((a_val == b_val) && a_wins_ties);
        win_val = take_a ? a_val : b_val;
        win_idx = take_a ? a_idx : b_idx;
    end

endmodule

`default_nettype wire

FILE: rtl/argmax_tournament_tree_unit.sv
// argmax tournament tree
// s_ channel: one request per item (operation, entry_index, operand_value);
// a write stores the score, an add adds it with saturation to 48 bits.
// m_ channel: one result per item (best_index, best_value, index_error),
// the maximum over live entries after the update, higher index on ties.
// cfg channel: writes entries_in_use, always ready; write only while idle.
// when all entries are live an item takes, from acceptance to result, one
// node memory read, one modify and the leaf-to-root path level by level,
// each level one pass through the shared comparator, then the load of the
// output register; the next request is taken once the sequencer is back
// in idle, so no new item is taken before the last reaches the register.
// with a lowered live count a prefix walk from the last live leaf to the
// root follows the update; a rejected index skips the update and takes the
// prefix walk only. s_ready is high only while idle. the output register
// frees the sequencer: a new request is taken while a result waits; if the
// receiver stalls the finished item waits in the sequencer until the
// register frees. after reset a clearing pass initialises the node memory
// while s_ready stays low.
`default_nettype none

module argmax_tournament_tree_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_operation,
    input  wire logic [$clog2(CAPACITY)-1:0]      s_entry_index,
    input  wire logic signed [att_pkg::VAL_W-1:0] s_operand_value,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [$clog2(CAPACITY)-1:0]      m_best_index,
    output logic signed [att_pkg::VAL_W-1:0]      m_best_value,
    output logic                                  m_index_error,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [$clog2(CAPACITY):0]        cfg_entries_in_use
);

    import att_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CFG_W  = IDX_W + 1;
    localparam int NODE_W = VAL_W + IDX_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  live_cfg_reg, live_cfg_next;

    op_t               op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [VAL_W-1:0]  operand_reg, operand_next;
    logic              err_reg, err_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic              full_reg, full_next;

    logic [ADDR_W-1:0] p_reg, p_next;
    logic [VAL_W-1:0]  acc_val_reg, acc_val_next;
    logic [IDX_W-1:0]  acc_idx_reg, acc_idx_next;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  clr_step_reg, clr_step_next;

    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [VAL_W-1:0]  out_val_reg, out_val_next;
    logic              out_err_reg, out_err_next;

    logic [CFG_W-1:0]  live_n;
    logic [CFG_W-1:0]  live_n_m1;
    logic [IDX_W-1:0]  live_last;
    logic              live_err;
    logic              out_free;
    logic              at_root;

    logic [ADDR_W-1:0] parent_addr;
    logic [ADDR_W-1:0] sib_addr;
    logic [ADDR_W-1:0] parent_sib_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic [NODE_W-1:0] rd_a_data;
    logic [NODE_W-1:0] rd_b_data;

    logic [VAL_W-1:0]  leaf_new_val;
    logic [VAL_W-1:0]  cmp_a_val;
    logic [IDX_W-1:0]  cmp_a_idx;
    logic [VAL_W-1:0]  cmp_win_val;
    logic [IDX_W-1:0]  cmp_win_idx;

    att_node_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (NODE_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    att_node_cmp #(
        .IDX_W (IDX_W)
    ) u_cmp (
        .a_val       (cmp_a_val),
        .a_idx       (cmp_a_idx),
        .b_val       (rd_b_data[NODE_W-1:IDX_W]),
        .b_idx       (rd_b_data[IDX_W-1:0]),
        .a_wins_ties (p_reg[0]),
        .win_val     (cmp_win_val),
        .win_idx     (cmp_win_idx)
    );

    // clamped live count and the last live leaf
    always_comb begin
        if (live_cfg_reg == '0) begin
            live_n = CFG_W'(1);
        end else if (live_cfg_reg > CFG_W'(CAPACITY)) begin
            live_n = CFG_W'(CAPACITY);
        end else begin
            live_n = live_cfg_reg;
        end
        live_n_m1 = live_n - CFG_W'(1);
        live_last = live_n_m1[IDX_W-1:0];
        live_err  = {1'b0, s_entry_index} >= live_n;
    end

    assign parent_addr     = p_reg >> 1;
    assign sib_addr        = p_reg ^ ADDR_W'(1);
    assign parent_sib_addr = parent_addr ^ ADDR_W'(1);
    assign at_root         = (p_reg == ADDR_W'(1));
    assign out_free        = !m_valid_reg || m_ready;
    assign leaf_new_val    = (op_reg == OP_ADD) ?
                             sat_add(rd_a_data[NODE_W-1:IDX_W], operand_reg) : operand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            live_cfg_reg <= CFG_W'(CAPACITY);
            m_valid_reg  <= 1'b0;
            clr_addr_reg <= {ADDR_W{1'b1}};
            clr_idx_reg  <= {IDX_W{1'b1}};
            clr_step_reg <= IDX_W'(1);
        end else begin
            state_reg    <= state_next;
            live_cfg_reg <= live_cfg_next;
            m_valid_reg  <= m_valid_next;
            clr_addr_reg <= clr_addr_next;
            clr_idx_reg  <= clr_idx_next;
            clr_step_reg <= clr_step_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        operand_reg <= operand_next;
        err_reg     <= err_next;
        last_reg    <= last_next;
        full_reg    <= full_next;
        p_reg       <= p_next;
        acc_val_reg <= acc_val_next;
        acc_idx_reg <= acc_idx_next;
        out_idx_reg <= out_idx_next;
        out_val_reg <= out_val_next;
        out_err_reg <= out_err_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = live_err ? S_Q_RD : S_LEAF_RD;
                end
            end
            S_LEAF_RD: state_next = S_MOD;
            S_MOD:     state_next = S_UP;
            S_UP: begin
                if (at_root) begin
                    state_next = full_reg ? S_DONE : S_Q_RD;
                end
            end
            S_Q_RD:    state_next = S_Q_LEAF;
            S_Q_LEAF:  state_next = S_Q_UP;
            S_Q_UP: begin
                if (at_root) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_CLEAR;
        endcase
    end

    // memory and comparator control
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = p_reg;
        wr_data   = {acc_val_reg, acc_idx_reg};
        rd_a_addr = p_reg;
        rd_b_addr = parent_sib_addr;
        cmp_a_val = acc_val_reg;
        cmp_a_idx = acc_idx_reg;
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = {{VAL_W{1'b0}}, clr_idx_reg};
            end
            S_LEAF_RD, S_Q_RD: begin
                rd_b_addr = sib_addr;
            end
            S_MOD: begin
                wr_en     = 1'b1;
                wr_data   = {leaf_new_val, idx_reg};
                cmp_a_val = leaf_new_val;
                cmp_a_idx = idx_reg;
            end
            S_UP: begin
                wr_en = 1'b1;
            end
            S_Q_LEAF: begin
                cmp_a_val = rd_a_data[NODE_W-1:IDX_W];
                cmp_a_idx = rd_a_data[IDX_W-1:0];
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        live_cfg_next = live_cfg_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        operand_next  = operand_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        full_next     = full_reg;
        p_next        = p_reg;
        acc_val_next  = acc_val_reg;
        acc_idx_next  = acc_idx_reg;
        clr_addr_next = clr_addr_reg;
        clr_idx_next  = clr_idx_reg;
        clr_step_next = clr_step_reg;
        out_idx_next  = out_idx_reg;
        out_val_next  = out_val_reg;
        out_err_next  = out_err_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cfg_valid) begin
            live_cfg_next = cfg_entries_in_use;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg - ADDR_W'(1);
                if ((clr_addr_reg & (clr_addr_reg - ADDR_W'(1))) == '0) begin
                    clr_idx_next  = {IDX_W{1'b1}};
                    clr_step_next = clr_step_reg << 1;
                end else begin
                    clr_idx_next = clr_idx_reg - clr_step_reg;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = op_t'(s_operation);
                    idx_next     = s_entry_index;
                    operand_next = s_operand_value;
                    err_next     = live_err;
                    last_next    = live_last;
                    full_next    = (live_last == {IDX_W{1'b1}});
                    p_next       = live_err ? {1'b1, live_last} : {1'b1, s_entry_index};
                end
            end
            S_MOD: begin
                acc_val_next = cmp_win_val;
                acc_idx_next = cmp_win_idx;
                p_next       = parent_addr;
            end
            S_UP: begin
                if (at_root) begin
                    p_next = {1'b1, last_reg};
                end else begin
                    acc_val_next = cmp_win_val;
                    acc_idx_next = cmp_win_idx;
                    p_next       = parent_addr;
                end
            end
            S_Q_LEAF: begin
                acc_val_next = p_reg[0] ? cmp_win_val : rd_a_data[NODE_W-1:IDX_W];
                acc_idx_next = p_reg[0] ? cmp_win_idx : rd_a_data[IDX_W-1:0];
                p_next       = parent_addr;
            end
            S_Q_UP: begin
                if (!at_root) begin
                    acc_val_next = p_reg[0] ? cmp_win_val : acc_val_reg;
                    acc_idx_next = p_reg[0] ? cmp_win_idx : acc_idx_reg;
                    p_next       = parent_addr;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_idx_next = acc_idx_reg;
                    out_val_next = acc_val_reg;
                    out_err_next = err_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                p_next = p_reg;
            end
        endcase
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_best_index  = out_idx_reg;
    assign m_best_value  = out_val_reg;
    assign m_index_error = out_err_reg;

endmodule

`default_nettype wire

FILE: sim/tb_argmax_tournament_tree_unit.sv
module tb_argmax_tournament_tree_unit;

    import att_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CFG_W    = IDX_W + 1;
    localparam int DRAIN_CYCLES = 2 * IDX_W + 10;
    localparam logic signed [VAL_W-1:0] SCORE_MAX = VAL_MAX;
    localparam logic signed [VAL_W-1:0] SCORE_MIN = VAL_MIN;

    typedef struct packed {
        logic [IDX_W-1:0]        best_index;
        logic signed [VAL_W-1:0] best_value;
        logic                    index_error;
    } best_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_operation;
    logic [IDX_W-1:0]        s_entry_index;
    logic signed [VAL_W-1:0] s_operand_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [IDX_W-1:0]        m_best_index;
    logic signed [VAL_W-1:0] m_best_value;
    logic                    m_index_error;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_W:0]          cfg_entries_in_use;

    logic signed [VAL_W-1:0] score_table [CAPACITY];
    int unsigned             live_entries;
    logic [IDX_W-1:0]        leader_index;
    best_result_t            pending_best [$];

    int send_idle_pct;
    int recv_stall_pct;
    int request_count;
    int result_count;
    int cfg_write_count;
    int error_count;

    argmax_tournament_tree_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_entry_index     (s_entry_index),
        .s_operand_value   (s_operand_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_best_index      (m_best_index),
        .m_best_value      (m_best_value),
        .m_index_error     (m_index_error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_entries_in_use(cfg_entries_in_use)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("argmax_tournament_tree_unit verification failed");
        $finish;
    end

    function automatic best_result_t update_and_rank(op_t op, logic [IDX_W-1:0] idx,
                                                     logic signed [VAL_W-1:0] operand);
        best_result_t            r;
        logic signed [VAL_W:0]   sum;
        int unsigned             k;
        r.index_error = (idx >= live_entries);
        if (!r.index_error) begin
            if (op == OP_WRITE) begin
                score_table[idx] = operand;
            end else begin
                sum = operand + score_table[idx];
                if (sum > SCORE_MAX) begin
                    score_table[idx] = SCORE_MAX;
                end else if (sum < SCORE_MIN) begin
                    score_table[idx] = SCORE_MIN;
                end else begin
                    score_table[idx] = sum[VAL_W-1:0];
                end
            end
        end
        r.best_index = '0;
        r.best_value = score_table[0];
        for (k = 1; k < live_entries; k++) begin
            if (score_table[k] >= r.best_value) begin
                r.best_value = score_table[k];
                r.best_index = k[IDX_W-1:0];
            end
        end
        leader_index = r.best_index;
        return r;
    endfunction

    task automatic send_request(op_t op, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_entry_index   <= idx;
        s_operand_value <= val;
        do @(posedge aclk); while (!s_ready);
        pending_best.push_back(update_and_rank(op, idx, val));
        request_count++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_best.size() != 0) @(posedge aclk);
    endtask

    task automatic set_live_entries(logic [IDX_W:0] n);
        wait_idle();
        @(negedge aclk);
        cfg_valid          <= 1'b1;
        cfg_entries_in_use <= n;
        do @(posedge aclk); while (!cfg_ready);
        if (n == 0) begin
            live_entries = 1;
        end else if (n > CAPACITY) begin
            live_entries = CAPACITY;
        end else begin
            live_entries = 32'(n);
        end
        cfg_write_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_request();
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic [63:0]             wide;
        int                      narrow;
        op = op_t'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: idx = IDX_W'($urandom_range(0, CAPACITY - 1));
            1: idx = leader_index;
            default: idx = IDX_W'($urandom_range(0, live_entries - 1));
        endcase
        case ($urandom_range(0, 7))
            0: val = SCORE_MAX;
            1: val = SCORE_MIN;
            2, 3: begin
                narrow = int'($urandom_range(0, 127)) - 64;
                val = VAL_W'(narrow);
            end
            default: begin
                wide = {$urandom(), $urandom()};
                val = wide[VAL_W-1:0];
            end
        endcase
        send_request(op, idx, val);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        best_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_best.size() == 0) begin
                $error("result with no request outstanding: index %0d value %0d",
                       m_best_index, m_best_value);
                error_count++;
            end else begin
                want = pending_best.pop_front();
                if (m_best_index !== want.best_index) begin
                    $error("best_index expected %0d actual %0d", want.best_index,
                           m_best_index);
                    error_count++;
                end
                if (m_best_value !== want.best_value) begin
                    $error("best_value expected %0d actual %0d", want.best_value,
                           m_best_value);
                    error_count++;
                end
                if (m_index_error !== want.index_error) begin
                    $error("index_error expected %0d actual %0d", want.index_error,
                           m_index_error);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_request(OP_ADD, 10'd0, 48'sd0);
        send_request(OP_WRITE, 10'd1023, 48'sd0);
        send_request(OP_WRITE, 10'd512, -48'sd1);
    endtask

    task automatic test_ties();
        send_request(OP_WRITE, 10'd10, 48'sd5);
        send_request(OP_WRITE, 10'd20, 48'sd5);
        send_request(OP_WRITE, 10'd3, 48'sd5);
        send_request(OP_ADD, 10'd3, 48'sd0);
    endtask

    task automatic test_saturation();
        send_request(OP_WRITE, 10'd100, SCORE_MAX);
        send_request(OP_WRITE, 10'd50, SCORE_MAX);
        send_request(OP_ADD, 10'd100, 48'sd1);
        send_request(OP_ADD, 10'd50, SCORE_MAX);
        send_request(OP_WRITE, 10'd100, SCORE_MIN);
        send_request(OP_ADD, 10'd100, -48'sd1);
        send_request(OP_ADD, 10'd200, SCORE_MIN);
        send_request(OP_ADD, 10'd200, SCORE_MIN);
        send_request(OP_ADD, 10'd200, SCORE_MAX);
    endtask

    task automatic test_live_count();
        send_request(OP_WRITE, 10'd900, SCORE_MAX);
        set_live_entries(11'd0);
        send_request(OP_WRITE, 10'd0, 48'sd7);
        send_request(OP_ADD, 10'd1, 48'sd9);
        send_request(OP_WRITE, 10'd1023, 48'sd9);
        set_live_entries(11'd3);
        send_request(OP_WRITE, 10'd2, 48'sd9);
        send_request(OP_WRITE, 10'd3, 48'sd100);
        set_live_entries(11'd2047);
        send_request(OP_ADD, 10'd1023, -48'sd3);
        set_live_entries(11'd1025);
        send_request(OP_WRITE, 10'd50, SCORE_MIN);
        set_live_entries(11'd1024);
        send_request(OP_ADD, 10'd0, 48'sd0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int setting_base);
        int c;
        logic [IDX_W:0] n;
        for (c = 0; c < 3; c++) begin
            case ((setting_base + c) % 12)
                0: n = 11'd1024;
                1: n = CFG_W'($urandom_range(1, CAPACITY));
                2: n = 11'd2;
                3: n = 11'd2047;
                4: n = 11'd1;
                5: n = CFG_W'($urandom_range(1, 64));
                6: n = 11'd0;
                7: n = 11'd700;
                8: n = CFG_W'($urandom_range(CAPACITY + 1, 2047));
                9: n = CFG_W'($urandom_range(1, CAPACITY));
                10: n = 11'd1500;
                default: n = 11'd1024;
            endcase
            set_live_entries(n);
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            repeat (75) send_random_request();
            wait_idle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < CAPACITY; k++) score_table[k] = '0;
        live_entries       = CAPACITY;
        leader_index       = IDX_W'(CAPACITY - 1);
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        request_count      = 0;
        result_count       = 0;
        cfg_write_count    = 0;
        error_count        = 0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_operation        = 1'b0;
        s_entry_index      = '0;
        s_operand_value    = '0;
        m_ready            = 1'b0;
        cfg_valid          = 1'b0;
        cfg_entries_in_use = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_ties();
        test_saturation();
        test_live_count();
        test_random_traffic(0, 0, 0);
        test_random_traffic(76, 0, 3);
        test_random_traffic(0, 76, 6);
        test_random_traffic(30, 30, 9);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests, %0d results, %0d live count writes",
                 request_count, result_count, cfg_write_count);
        $display("writes, saturating adds, ties, rejected indices; %0d mismatches",
                 error_count);
        if (error_count == 0 && pending_best.size() == 0) begin
            $display("argmax_tournament_tree_unit verification clean");
        end else begin
            $display("argmax_tournament_tree_unit verification failed");
        end
        $finish;
    end

endmodule
